### design/assert_macros.svh
// Assertion macros shared by the prime field unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define PFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define PFA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### design/pfa_pkg.sv
// Shared constants, opcodes, states and control structs of the prime field unit.
package pfa_pkg;

    localparam logic [29:0] P_MOD      = 30'd1000000007;
    // floor(2^60 / P) for Barrett reduction
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;
    localparam logic [31:0] SQRT_EXP   = 32'd250000002;
    localparam logic [31:0] LEG_EXP    = 32'd500000003;
    localparam logic [31:0] INV_EXP    = 32'd1000000005;
    localparam int unsigned MUL_LAT    = 5;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_INV, OP_POW, OP_SQRT, OP_LEG
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_REDUCE, S_MUL_WAIT, S_POW_CHECK, S_POW_WAIT, S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic fire;
        logic latch_mul;
        logic latch_pow;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic b_ge_p;
        logic mul_done;
        logic exp_zero;
        logic out_full;
    } t_sts;

endpackage

### design/pfa_if.sv
// Request and response channel interfaces.
interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [29:0] operand_a;
    logic [31:0] operand_b;
    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [29:0] value;
    logic        is_residue;
    logic        operand_error;
    modport source (output valid, value, is_residue, operand_error, input ready);
    modport sink   (input valid, value, is_residue, operand_error, output ready);
endinterface

### design/pfa_modmul.sv
// Pipelined modular multiplier with Barrett reduction, fixed latency.
`include "assert_macros.svh"
module pfa_modmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [29:0] i_x,
    input  logic [29:0] i_y,
    output logic        o_valid,
    output logic [29:0] o_r
);
    import pfa_pkg::*;

    localparam logic [31:0] P32 = {2'b00, P_MOD};
    localparam logic [31:0] P2  = {1'b0, P_MOD, 1'b0};

    logic [MUL_LAT-1:0] r_vld;
    logic [59:0] r_prod;
    logic [61:0] r_q2;
    logic [31:0] r_plo1;
    logic [31:0] r_plo2;
    logic [31:0] r_t;
    logic [31:0] r_rem;
    logic [29:0] r_res;
    logic [30:0] q1;
    logic [30:0] q3;

    assign q1 = r_prod[59:29];
    assign q3 = r_q2[61:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[MUL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 60'(i_x) * 60'(i_y);
        r_q2   <= 62'(q1) * 62'(BARRETT_MU);
        r_plo1 <= r_prod[31:0];
        r_t    <= 32'(q3) * P32;   // low word only, remainder is below 3P
        r_plo2 <= r_plo1;
        r_rem  <= r_plo2 - r_t;
        if (r_rem >= P2) begin
            r_res <= 30'(r_rem - P2);
        end else if (r_rem >= P32) begin
            r_res <= 30'(r_rem - P32);
        end else begin
            r_res <= r_rem[29:0];
        end
    end

    assign o_valid = r_vld[MUL_LAT-1];
    assign o_r     = r_res;

    `PFA_ASSERT(a_mm_latency, i_valid |-> ##5 o_valid, "modmul latency broken")
    `PFA_ASSERT(a_mm_reduced, o_valid |-> (o_r < P_MOD), "modmul result not reduced")
endmodule

### design/pfa_datapath.sv
// Operand registers, exponent shifter, field add/sub/negate and output register.
`include "assert_macros.svh"
module pfa_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfa_pkg::t_cmd i_cmd,
    output pfa_pkg::t_sts o_sts,
    input  logic [2:0]    i_req_type,
    input  logic [29:0]   i_operand_a,
    input  logic [31:0]   i_operand_b,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [29:0]   o_value,
    output logic          o_is_residue,
    output logic          o_operand_error
);
    import pfa_pkg::*;

    localparam logic [31:0] P32 = {2'b00, P_MOD};

    t_op         r_op;
    logic [29:0] r_a;
    logic [31:0] r_b;
    logic        r_err;
    logic [29:0] r_acc;
    logic [29:0] r_base;
    logic [31:0] r_exp;
    logic        r_out_valid;
    logic [29:0] r_value;
    logic        r_res;
    logic        r_oerr;

    t_op         in_op;
    logic [29:0] m0_x, m0_y, m0_r, m1_r;
    logic        m0_v, m1_v;
    logic [29:0] rb;
    logic [30:0] sum;
    logic [29:0] fin_val;

    assign in_op = t_op'(i_req_type);
    assign rb    = r_b[29:0];
    assign sum   = {1'b0, r_a} + {1'b0, rb};

    assign m0_x = (r_op == OP_MUL) ? r_a : r_acc;
    assign m0_y = (r_op == OP_MUL) ? rb  : r_base;

    pfa_modmul u_mul0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_cmd.fire),
        .i_x(m0_x), .i_y(m0_y), .o_valid(m0_v), .o_r(m0_r)
    );

    pfa_modmul u_mul1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_cmd.fire),
        .i_x(r_base), .i_y(r_base), .o_valid(m1_v), .o_r(m1_r)
    );

    always_comb begin
        case (r_op)
            OP_ADD:  fin_val = (sum >= {1'b0, P_MOD}) ? 30'(sum - {1'b0, P_MOD}) : sum[29:0];
            OP_SUB:  fin_val = (r_a >= rb) ? (r_a - rb) : (r_a + (P_MOD - rb));
            OP_NEG:  fin_val = (r_a == '0) ? '0 : (P_MOD - r_a);
            default: fin_val = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= in_op;
            r_a    <= (i_operand_a >= P_MOD) ? (i_operand_a - P_MOD) : i_operand_a;
            r_base <= (i_operand_a >= P_MOD) ? (i_operand_a - P_MOD) : i_operand_a;
            r_b    <= i_operand_b;
            r_acc  <= 30'd1;
            r_err  <= (i_operand_a >= P_MOD) ||
                      ((in_op == OP_ADD || in_op == OP_SUB || in_op == OP_MUL) &&
                       (i_operand_b >= P32));
            case (in_op)
                OP_POW:  r_exp <= i_operand_b;
                OP_SQRT: r_exp <= SQRT_EXP;
                OP_LEG:  r_exp <= LEG_EXP;
                OP_INV:  r_exp <= INV_EXP;   // Fermat: a^(P-2), zero maps to zero
                default: r_exp <= '0;
            endcase
        end
        if (i_cmd.reduce && r_b >= P32) begin
            r_b <= r_b - P32;
        end
        if (i_cmd.latch_mul) begin
            r_acc <= m0_r;
        end
        if (i_cmd.latch_pow) begin
            if (r_exp[0]) begin
                r_acc <= m0_r;
            end
            r_base <= m1_r;
            r_exp  <= r_exp >> 1;
        end
        if (i_cmd.finish) begin
            r_value <= fin_val;
            r_res   <= (r_op == OP_LEG) && (r_acc == 30'd1);
            r_oerr  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.b_ge_p   = (r_b >= P32);
    assign o_sts.mul_done = m0_v && m1_v;
    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.out_full = r_out_valid;

    assign o_valid         = r_out_valid;
    assign o_value         = r_value;
    assign o_is_residue    = r_res;
    assign o_operand_error = r_oerr;

    `PFA_ASSERT(a_dp_shift, i_cmd.latch_pow |=> (r_exp == ($past(r_exp) >> 1)), "exponent not shifted")
    `PFA_ASSERT(a_dp_finish, i_cmd.finish |=> r_out_valid, "result not registered")
    `PFA_ASSERT_RST(a_dp_reset, !i_rst_n |=> !r_out_valid, "output valid after reset")
endmodule

### design/pfa_ctrl.sv
// Controller state machine sequencing reduction, multiplies and power rounds.
`include "assert_macros.svh"
module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pfa_pkg::t_sts i_sts,
    output pfa_pkg::t_cmd o_cmd
);
    import pfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_req_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_sts.op) inside
                    OP_ADD, OP_SUB, OP_MUL: n_state = S_REDUCE;
                    OP_NEG:                 n_state = S_FINISH;
                    default:                n_state = S_POW_CHECK;
                endcase
            end
            S_REDUCE: begin
                if (!i_sts.b_ge_p) begin
                    n_state = (i_sts.op == OP_MUL) ? S_MUL_WAIT : S_FINISH;
                end
            end
            S_MUL_WAIT:  if (i_sts.mul_done) n_state = S_FINISH;
            S_POW_CHECK: n_state = i_sts.exp_zero ? S_FINISH : S_POW_WAIT;
            S_POW_WAIT:  if (i_sts.mul_done) n_state = S_POW_CHECK;
            S_FINISH:    if (!i_sts.out_full) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_REDUCE: begin
                o_cmd.reduce = i_sts.b_ge_p;
                o_cmd.fire   = !i_sts.b_ge_p && (i_sts.op == OP_MUL);
            end
            S_MUL_WAIT:  o_cmd.latch_mul = i_sts.mul_done;
            S_POW_CHECK: o_cmd.fire      = !i_sts.exp_zero;
            S_POW_WAIT:  o_cmd.latch_pow = i_sts.mul_done;
            S_FINISH:    o_cmd.finish    = !i_sts.out_full;
            default:     o_cmd           = '0;
        endcase
    end

    `PFA_ASSERT(a_ctl_onecmd, $onehot0(o_cmd), "several commands at once")
    `PFA_ASSERT(a_ctl_fire, o_cmd.fire |-> ##5 i_sts.mul_done, "multiply result missing")
    `PFA_ASSERT(a_ctl_load, o_cmd.load |=> (r_state == S_DISPATCH), "load not dispatched")
endmodule

### design/prime_field_arithmetic_unit_top.sv
// Top level of the prime field arithmetic unit, modulus 1000000007.
// Usage:
//   i_req carries one item: req_type, operand_a, operand_b. It is taken when
//   valid and ready are both high; ready is high only while the controller is
//   idle, so one item is in flight at a time.
//   o_rsp returns exactly one item per request: value, is_residue and
//   operand_error, held in an output register until the receiver takes it.
//   A new request is accepted while that result still waits; a stalled
//   receiver only holds the block once the next result is ready to go out.
// Operations:
//   negate needs no multiply; add, sub: up to four subtract steps reduce b.
//   mul: the 5-stage Barrett multiplier, after the b reduction.
//   power, sqrt, legendre, inverse: each exponent bit costs one pass
//   through the two parallel multipliers (square and multiply).
//   Inverse is computed as a^(P-2), which also gives 0 for zero.
// The next item is taken once the result has registered and the
// controller is back in idle.
// Reset: synchronous, active low; clears the controller and the output
// valid flag. There is no configuration and no state kept between items.
module prime_field_arithmetic_unit_top (
    input  logic i_clk,
    input  logic i_rst_n,
    pfa_req_if.sink   i_req,
    pfa_rsp_if.source o_rsp
);
    import pfa_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req.req_type),
        .i_operand_a     (i_req.operand_a),
        .i_operand_b     (i_req.operand_b),
        .o_valid         (o_rsp.valid),
        .i_ready         (o_rsp.ready),
        .o_value         (o_rsp.value),
        .o_is_residue    (o_rsp.is_residue),
        .o_operand_error (o_rsp.operand_error)
    );

    assign i_req.ready = req_ready;
endmodule

### dv/prime_field_arithmetic_unit_top_tb.sv
// Testbench for the prime field arithmetic unit: random and directed requests, scoreboard check.
module prime_field_arithmetic_unit_top_tb;
    import pfa_pkg::*;

    localparam longint unsigned FP = 64'd1000000007;

    // One expected response
    typedef struct {
        logic [29:0] value;
        logic        is_residue;
        logic        operand_error;
    } t_field_result;

    // Modular power by square and multiply
    function automatic longint unsigned field_pow(longint unsigned base, longint unsigned e);
        longint unsigned acc;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = (acc * base) % FP;
            base = (base * base) % FP;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Inverse by extended Euclid; zero has none
    function automatic longint unsigned field_inv(longint unsigned x);
        longint r0, r1, t0, t1, q, nr, nt;
        r0 = FP; r1 = x; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            nr = r0 - q * r1; nt = t0 - q * t1;
            r0 = r1; r1 = nr; t0 = t1; t1 = nt;
        end
        if (r0 != 1) return 0;
        t0 = t0 % longint'(FP);
        if (t0 < 0) t0 += FP;
        return t0;
    endfunction

    function automatic t_field_result field_predict(logic [2:0] op, logic [29:0] ra,
                                                    logic [31:0] rb);
        t_field_result r;
        longint unsigned a, b, v;
        a = ra % FP; b = rb % FP;
        r.is_residue = 1'b0;
        r.operand_error = (ra >= FP) || (op <= OP_MUL && rb >= FP);
        case (t_op'(op))
            OP_ADD:  v = (a + b) % FP;
            OP_SUB:  v = (a + FP - b) % FP;
            OP_MUL:  v = (a * b) % FP;
            OP_NEG:  v = (a != 0) ? FP - a : 0;
            OP_INV:  v = (a != 0) ? field_inv(a) : 0;
            OP_POW:  v = field_pow(a, rb);
            OP_SQRT: v = field_pow(a, SQRT_EXP);
            default: begin
                v = field_pow(a, LEG_EXP);
                r.is_residue = (v == 1);
            end
        endcase
        r.value = v[29:0];
        return r;
    endfunction

    class field_scoreboard;
        t_field_result pending[$];
        int errors = 0;

        function void note_request(logic [2:0] op, logic [29:0] a, logic [31:0] b);
            pending.insert(pending.size(), field_predict(op, a, b));
        endfunction

        function void check_response(logic [29:0] v, logic res, logic err);
            t_field_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d", $time, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value) begin
                $display("%0t: value expected %0d actual %0d", $time, e.value, v);
                errors++;
            end
            if (res !== e.is_residue) begin
                $display("%0t: is_residue expected %0b actual %0b", $time, e.is_residue, res);
                errors++;
            end
            if (err !== e.operand_error) begin
                $display("%0t: operand_error expected %0b actual %0b",
                         $time, e.operand_error, err);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    pfa_req_if req_ch();
    pfa_rsp_if rsp_ch();
    field_scoreboard sb = new();

    // Idle switches; long stretches with no gaps are set by the stimulus
    bit src_gaps = 1'b1;
    bit snk_gaps = 1'b1;
    bit snk_hold = 1'b0;

    prime_field_arithmetic_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready = 1'b0;
    end

    // Offer one item, with a random gap beforehand, and wait for acceptance.
    // Valid stays high after acceptance so back-to-back items need no gap.
    task automatic send_request(logic [2:0] op, logic [29:0] a, logic [31:0] b);
        while (src_gaps && $urandom_range(99) < 33) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(op, a, b);
    endtask

    // Withdraw valid once the sender stops offering
    task automatic stop_source();
        req_ch.valid <= 1'b0;
    endtask

    // Operand values weighted towards the edges of the field
    function automatic logic [29:0] pick_a();
        case ($urandom_range(9))
            0: return 30'd0;
            1: return 30'd1;
            2: return 30'(FP - 1);
            3: return 30'(FP + $urandom_range(30'h3FFFFFFF - 30'(FP)));
            default: return 30'($urandom_range(30'(FP - 1)));
        endcase
    endfunction

    function automatic logic [31:0] pick_b(logic [2:0] op);
        if (op == OP_POW) begin
            case ($urandom_range(5))
                0: return 32'd0;
                1: return 32'hFFFF_FFFF;
                2: return 32'($urandom_range(64));
                default: return $urandom;
            endcase
        end
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'(FP - 1);
            2: return 32'hFFFF_FFFF;
            3: return 32'(FP) + $urandom_range(32'hFFFF_FFFF - 32'(FP));
            default: return 32'($urandom_range(32'(FP - 1)));
        endcase
    endfunction

    task automatic send_random(int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            op = 3'($urandom_range(7));
            send_request(op, pick_a(), pick_b(op));
        end
    endtask

    // Receiver: random gaps, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp_ch.ready <= 1'b0;
        else if (snk_hold)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !(snk_gaps && $urandom_range(99) < 33);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.value, rsp_ch.is_residue, rsp_ch.operand_error);
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each operation, special cases
        send_request(OP_ADD, 30'(FP - 1), 32'(FP - 1));
        send_request(OP_ADD, 30'h3FFF_FFFF, 32'hFFFF_FFFF);   // both operands out of range
        send_request(OP_SUB, 30'd0, 32'(FP - 1));
        send_request(OP_SUB, 30'd5, 32'(FP));                 // b just at the modulus
        send_request(OP_MUL, 30'(FP - 1), 32'(FP - 1));
        send_request(OP_MUL, 30'(FP), 32'd7);                 // a just at the modulus
        send_request(OP_NEG, 30'd0, 32'hFFFF_FFFF);           // b ignored, no error
        send_request(OP_NEG, 30'd1, 32'd0);
        send_request(OP_INV, 30'd0, 32'd0);                   // no inverse for zero
        send_request(OP_INV, 30'd2, 32'd0);
        send_request(OP_INV, 30'(FP - 1), 32'd0);
        send_request(OP_POW, 30'd0, 32'd0);                   // zero to the zero
        send_request(OP_POW, 30'd3, 32'hFFFF_FFFF);           // exponent not flagged
        send_request(OP_POW, 30'(FP - 1), 32'd1);
        send_request(OP_SQRT, 30'd4, 32'd0);
        send_request(OP_SQRT, 30'd5, 32'd0);                  // non-residue, unchecked
        send_request(OP_SQRT, 30'd0, 32'd0);
        send_request(OP_LEG, 30'd4, 32'd0);
        send_request(OP_LEG, 30'd5, 32'd0);
        send_request(OP_LEG, 30'd0, 32'd0);
        send_request(OP_LEG, 30'h3FFF_FFFF, 32'd0);

        send_random(600);

        // Receiver holds off while the sender keeps offering
        fork
            begin
                snk_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                snk_hold = 1'b0;
            end
            begin
                send_random(20);
                stop_source();
            end
        join

        // Sender pauses until everything has drained
        while (sb.pending.size() != 0) @(posedge i_clk);

        // No idling on either side
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
        send_random(300);
        src_gaps = 1'b1;
        snk_gaps = 1'b1;

        send_random(680);
        stop_source();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### prime_field_arithmetic_unit_top.f
+incdir+design
design/pfa_pkg.sv
design/pfa_if.sv
design/pfa_modmul.sv
design/pfa_datapath.sv
design/pfa_ctrl.sv
design/prime_field_arithmetic_unit_top.sv
dv/prime_field_arithmetic_unit_top_tb.sv
